/* rtl/gcb_pkg.sv */
// gcb_pkg: shared constants, types and fixed-point helpers for the
// great-circle bearing unit. No dependencies.
package gcb_pkg;

   // angles in 1e-7 degree
   localparam logic [31:0] DEG90 = 32'd900000000;
   localparam logic [31:0] DEG180 = 32'd1800000000;
   localparam logic [31:0] DEG360 = 32'd3600000000;
   localparam logic signed [33:0] DEG90_S = 34'sd900000000;
   localparam logic signed [33:0] DEG180_S = 34'sd1800000000;
   localparam logic signed [33:0] DEG360_S = 34'sd3600000000;

   // Q30 radians
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [31:0] PI_HALF = PI_Q30 / 32'd2;
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;
   localparam logic [31:0] GAIN_INV_Q30 = 32'd652032874;

   // reciprocals for the constant dividers
   localparam logic [63:0] RECIP_DEG = 64'h2000_0000_0000_0000 / 64'd1800000000;
   localparam logic [65:0] RECIP_PI = 66'h1_0000_0000_0000_0000 / 66'd3373259426;

   // fixed register count of the sin/cos unit ahead of and after its rotations
   localparam int SC_FIXED_LAT = 6;

   localparam logic [31:0] ATAN_TAB [0:31] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000};

   typedef logic signed [31:0] q30_type;

   typedef struct packed {
      q30_type s;
      q30_type c;
   } sc_type;

   typedef struct packed {
      logic neg;
      logic negc;
      logic zero;
      logic n90p;
      logic n90n;
   } sc_flags_type;

   typedef struct packed {
      logic eq;
      logic yz;
      logic xn;
   } vec_flags_type;

   // rounded Q30 product
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      return q30_type'(p >>> 30);
   endfunction

endpackage

/* rtl/gcb_req_if.sv */
// gcb_req_if: request channel of the bearing unit, a start and an end point.
// Depends on nothing.
interface gcb_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] from_lon;
   logic signed [30:0] from_lat;
   logic signed [31:0] to_lon;
   logic signed [30:0] to_lat;

   modport source(output valid, from_lon, from_lat, to_lon, to_lat, input ready);
   modport sink(input valid, from_lon, from_lat, to_lon, to_lat, output ready);
endinterface

/* rtl/gcb_rsp_if.sv */
// gcb_rsp_if: response channel of the bearing unit, one bearing per transfer.
// Depends on nothing.
interface gcb_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] bearing;

   modport source(output valid, bearing, input ready);
   modport sink(input valid, bearing, output ready);
endinterface

/* rtl/gcb_sincos.sv */
// gcb_sincos: pipelined sine/cosine of an angle in 1e-7 degree, Q30 results.
// Quadrant fold, degree to radian scaling, then one CORDIC rotation per stage.
// Depends on gcb_pkg.
module gcb_sincos #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [31:0]   angle,
   output gcb_pkg::sc_type      result
);

   localparam logic [33:0] D1_34 = 34'(gcb_pkg::DEG180);
   localparam logic [33:0] D2_34 = 34'(gcb_pkg::DEG360);
   localparam logic [33:0] D3_34 = D1_34 + D2_34;

   // fold into [-90, 90] degrees
   logic signed [33:0] a34;
   logic signed [33:0] fold;
   logic [29:0] m1_in;
   gcb_pkg::sc_flags_type fl1_in;
   logic [29:0] m1_ff;
   gcb_pkg::sc_flags_type fl1_ff;

   always_comb begin
      a34 = 34'(angle);
      fl1_in = '0;
      if (a34 > gcb_pkg::DEG90_S) begin
         fold = gcb_pkg::DEG180_S - a34;
         fl1_in.negc = 1'b1;
      end else if (a34 < -gcb_pkg::DEG90_S) begin
         fold = -gcb_pkg::DEG180_S - a34;
         fl1_in.negc = 1'b1;
      end else begin
         fold = a34;
      end
      fl1_in.neg = fold < 0;
      fl1_in.zero = fold == 0;
      fl1_in.n90p = fold == gcb_pkg::DEG90_S;
      fl1_in.n90n = fold == -gcb_pkg::DEG90_S;
      m1_in = fold < 0 ? 30'(-fold) : 30'(fold);
   end

   // radians = (m*pi + 90deg) / 180deg, reciprocal estimate then fix-up
   logic [61:0] n2_in;
   logic [61:0] n2_ff;
   gcb_pkg::sc_flags_type fl2_ff;
   logic [63:0] p3;
   logic [30:0] q3_ff;
   logic [33:0] nl3_ff;
   gcb_pkg::sc_flags_type fl3_ff;
   logic [61:0] p4;
   logic [33:0] rem4_in;
   logic [33:0] rem4_ff;
   logic [30:0] q4_ff;
   gcb_pkg::sc_flags_type fl4_ff;
   logic [1:0] corr5;
   logic [31:0] q5;

   assign n2_in = 62'(m1_ff) * 62'(gcb_pkg::PI_Q30) + 62'(gcb_pkg::DEG90);
   assign p3 = 64'(n2_ff[61:29]) * 64'(gcb_pkg::RECIP_DEG[30:0]);
   assign p4 = 62'(q3_ff) * 62'(gcb_pkg::DEG180);
   assign rem4_in = nl3_ff - p4[33:0];
   assign corr5 = 2'(rem4_ff >= D1_34) + 2'(rem4_ff >= D2_34) + 2'(rem4_ff >= D3_34);
   assign q5 = 32'(q4_ff) + 32'(corr5);

   gcb_pkg::q30_type x_ff [CORDIC_STAGES+1];
   gcb_pkg::q30_type y_ff [CORDIC_STAGES+1];
   gcb_pkg::q30_type z_ff [CORDIC_STAGES+1];
   gcb_pkg::sc_flags_type fl_ff [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         fl1_ff <= fl1_in;
         n2_ff <= n2_in;
         fl2_ff <= fl1_ff;
         q3_ff <= p3[62:32];
         nl3_ff <= n2_ff[33:0];
         fl3_ff <= fl2_ff;
         rem4_ff <= rem4_in;
         q4_ff <= q3_ff;
         fl4_ff <= fl3_ff;
         x_ff[0] <= gcb_pkg::q30_type'(gcb_pkg::GAIN_INV_Q30);
         y_ff[0] <= '0;
         z_ff[0] <= fl4_ff.neg ? -gcb_pkg::q30_type'(q5) : gcb_pkg::q30_type'(q5);
         fl_ff[0] <= fl4_ff;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      gcb_pkg::q30_type x_in;
      gcb_pkg::q30_type y_in;
      gcb_pkg::q30_type z_in;
      always_comb begin
         if (!z_ff[i][31]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - $signed(gcb_pkg::ATAN_TAB[i]);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + $signed(gcb_pkg::ATAN_TAB[i]);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            fl_ff[i+1] <= fl_ff[i];
         end
      end
   end

   // exact answers at zero and right angles, then cosine sign
   gcb_pkg::sc_flags_type fl_o;
   gcb_pkg::q30_type c_raw;
   gcb_pkg::sc_type result_in;
   gcb_pkg::sc_type result_ff;

   always_comb begin
      fl_o = fl_ff[CORDIC_STAGES];
      if (fl_o.zero) begin
         result_in.s = '0;
         c_raw = gcb_pkg::q30_type'(gcb_pkg::ONE_Q30);
      end else if (fl_o.n90p) begin
         result_in.s = gcb_pkg::q30_type'(gcb_pkg::ONE_Q30);
         c_raw = '0;
      end else if (fl_o.n90n) begin
         result_in.s = -gcb_pkg::q30_type'(gcb_pkg::ONE_Q30);
         c_raw = '0;
      end else begin
         result_in.s = y_ff[CORDIC_STAGES];
         c_raw = x_ff[CORDIC_STAGES];
      end
      result_in.c = fl_o.negc ? -c_raw : c_raw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* rtl/great_circle_bearing_unit.sv */
// great_circle_bearing_unit: initial great-circle bearing between two points.
// Three pipelined sin/cos units, Q30 products, a vectoring CORDIC and a
// constant divider back to 1e-7 degree. Depends on gcb_pkg, gcb_sincos and
// the gcb_req_if / gcb_rsp_if channels.
//
// req_ch carries start and end longitude/latitude in 1e-7 degree; rsp_ch
// returns the bearing clockwise from north in 1e-7 degree, in [0, 360 deg).
// Identical points give 0. Both channels use valid/ready; a transfer happens
// when both are high on a rising clock edge.
// Throughput is one pair per cycle while rsp_ch is not holding a result back.
// The two CORDIC chains hold one register per iteration.
// The whole pipeline moves as one: when rsp_ch holds a result that is not
// taken, every stage holds and req_ch.ready drops in the same cycle; no item
// is lost or repeated. Bubbles travel as cleared valid bits.
// Synchronous reset clears all valid bits and holds req_ch.ready low; data
// registers are not reset.
// Results come back in request order.
module great_circle_bearing_unit #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        reset,
   gcb_req_if.sink     req_ch,
   gcb_rsp_if.source   rsp_ch
);

   localparam int SC_LAT = gcb_pkg::SC_FIXED_LAT + CORDIC_STAGES;
   localparam logic signed [34:0] PI_S = 35'(gcb_pkg::PI_Q30);
   localparam logic signed [34:0] TWO_PI_S = PI_S <<< 1;
   localparam logic [34:0] PI1_35 = 35'(gcb_pkg::PI_Q30);
   localparam logic [34:0] PI2_35 = PI1_35 << 1;
   localparam logic [34:0] PI3_35 = PI1_35 + PI2_35;

   logic en;
   logic out_v_ff;
   logic [31:0] out_bearing_ff;

   assign en = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en && !reset;
   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.bearing = out_bearing_ff;

   // input register
   logic in_v_ff;
   logic signed [31:0] lon1_ff;
   logic signed [30:0] lat1_ff;
   logic signed [31:0] lon2_ff;
   logic signed [30:0] lat2_ff;

   // longitude difference wrapped to [-180, 180)
   logic signed [33:0] d34;
   logic signed [33:0] dw;
   logic signed [31:0] dlon_in;
   logic w_eq_in;
   logic w_v_ff;
   logic w_eq_ff;
   logic signed [31:0] w_lat1_ff;
   logic signed [31:0] w_lat2_ff;
   logic signed [31:0] w_dlon_ff;

   always_comb begin
      d34 = 34'(lon2_ff) - 34'(lon1_ff);
      if (d34 >= gcb_pkg::DEG180_S) begin
         dw = d34 - gcb_pkg::DEG360_S;
      end else if (d34 < -gcb_pkg::DEG180_S) begin
         dw = d34 + gcb_pkg::DEG360_S;
      end else begin
         dw = d34;
      end
      dlon_in = 32'(dw);
      w_eq_in = (dlon_in == 0) && (lat1_ff == lat2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lon1_ff <= req_ch.from_lon;
         lat1_ff <= req_ch.from_lat;
         lon2_ff <= req_ch.to_lon;
         lat2_ff <= req_ch.to_lat;
         w_lat1_ff <= 32'(lat1_ff);
         w_lat2_ff <= 32'(lat2_ff);
         w_dlon_ff <= dlon_in;
         w_eq_ff <= w_eq_in;
      end
   end

   gcb_pkg::sc_type sc1;
   gcb_pkg::sc_type sc2;
   gcb_pkg::sc_type scd;

   gcb_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_lat1 (
      .clock(clock), .en(en), .angle(w_lat1_ff), .result(sc1));
   gcb_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_lat2 (
      .clock(clock), .en(en), .angle(w_lat2_ff), .result(sc2));
   gcb_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_dlon (
      .clock(clock), .en(en), .angle(w_dlon_ff), .result(scd));

   // valid and same-point flag alongside the sin/cos units
   logic [SC_LAT-1:0] sc_v_ff;
   logic [SC_LAT-1:0] sc_eq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sc_eq_ff <= {sc_eq_ff[SC_LAT-2:0], w_eq_ff};
      end
   end

   // y = sd*c2, x = c1*s2 - s1*c2*cd
   logic m1_v_ff;
   logic m1_eq_ff;
   gcb_pkg::q30_type m1_y_ff;
   gcb_pkg::q30_type m1_t_ff;
   gcb_pkg::q30_type m1_u_ff;
   gcb_pkg::q30_type m1_cd_ff;
   logic m2_v_ff;
   logic m2_eq_ff;
   logic signed [32:0] m2_x_ff;
   gcb_pkg::q30_type m2_y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1_y_ff <= gcb_pkg::mul_q30(scd.s, sc2.c);
         m1_t_ff <= gcb_pkg::mul_q30(sc1.s, sc2.c);
         m1_u_ff <= gcb_pkg::mul_q30(sc1.c, sc2.s);
         m1_cd_ff <= scd.c;
         m1_eq_ff <= sc_eq_ff[SC_LAT-1];
         m2_x_ff <= 33'(m1_u_ff) - 33'(gcb_pkg::mul_q30(m1_t_ff, m1_cd_ff));
         m2_y_ff <= m1_y_ff;
         m2_eq_ff <= m1_eq_ff;
      end
   end

   // vectoring CORDIC, left half plane turned over first
   logic signed [34:0] vx_ff [CORDIC_STAGES+1];
   logic signed [34:0] vy_ff [CORDIC_STAGES+1];
   logic signed [34:0] vz_ff [CORDIC_STAGES+1];
   gcb_pkg::vec_flags_type vf_ff [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0] vv_ff;

   logic signed [34:0] v0_x_in;
   logic signed [34:0] v0_y_in;
   logic signed [34:0] v0_z_in;
   gcb_pkg::vec_flags_type v0_f_in;

   always_comb begin
      v0_f_in.eq = m2_eq_ff;
      v0_f_in.yz = m2_y_ff == 0;
      v0_f_in.xn = m2_x_ff < 0;
      if (v0_f_in.xn) begin
         v0_x_in = -35'(m2_x_ff);
         v0_y_in = -35'(m2_y_ff);
         v0_z_in = (m2_y_ff > 0) ? PI_S : -PI_S;
      end else begin
         v0_x_in = 35'(m2_x_ff);
         v0_y_in = 35'(m2_y_ff);
         v0_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0] <= v0_x_in;
         vy_ff[0] <= v0_y_in;
         vz_ff[0] <= v0_z_in;
         vf_ff[0] <= v0_f_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      logic signed [34:0] x_in;
      logic signed [34:0] y_in;
      logic signed [34:0] z_in;
      always_comb begin
         if (vy_ff[i] > 0) begin
            x_in = vx_ff[i] + (vy_ff[i] >>> i);
            y_in = vy_ff[i] - (vx_ff[i] >>> i);
            z_in = vz_ff[i] + 35'(gcb_pkg::ATAN_TAB[i]);
         end else begin
            x_in = vx_ff[i] - (vy_ff[i] >>> i);
            y_in = vy_ff[i] + (vx_ff[i] >>> i);
            z_in = vz_ff[i] - 35'(gcb_pkg::ATAN_TAB[i]);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            vx_ff[i+1] <= x_in;
            vy_ff[i+1] <= y_in;
            vz_ff[i+1] <= z_in;
            vf_ff[i+1] <= vf_ff[i];
         end
      end
   end

   // angle into [0, 2pi)
   gcb_pkg::vec_flags_type vf_o;
   logic signed [34:0] zs;
   logic signed [34:0] zw;
   logic [32:0] zs_in;
   logic zs_v_ff;
   logic zs_eq_ff;
   logic [32:0] zs_ff;

   always_comb begin
      vf_o = vf_ff[CORDIC_STAGES];
      if (vf_o.yz) begin
         zs = vf_o.xn ? PI_S : '0;
      end else begin
         zs = vz_ff[CORDIC_STAGES];
      end
      zw = (zs < 0) ? zs + TWO_PI_S : zs;
      zs_in = (zw < 0) ? '0 : 33'(zw);
   end

   // bearing = (z*180deg + pi/2) / pi
   logic d1_v_ff;
   logic d1_eq_ff;
   logic [63:0] d1_n_ff;
   logic [64:0] p2;
   logic d2_v_ff;
   logic d2_eq_ff;
   logic [32:0] d2_q_ff;
   logic [34:0] d2_nl_ff;
   logic [64:0] p3;
   logic d3_v_ff;
   logic d3_eq_ff;
   logic [32:0] d3_q_ff;
   logic [34:0] d3_rem_ff;
   logic [1:0] corr4;
   logic [33:0] b_sum;
   logic [33:0] b_wrap;
   logic [31:0] bearing_in;

   assign p2 = 65'(d1_n_ff[63:32]) * 65'(gcb_pkg::RECIP_PI[32:0]);
   assign p3 = 65'(d2_q_ff) * 65'(gcb_pkg::PI_Q30);

   always_comb begin
      corr4 = 2'(d3_rem_ff >= PI1_35) + 2'(d3_rem_ff >= PI2_35) + 2'(d3_rem_ff >= PI3_35);
      b_sum = 34'(d3_q_ff) + 34'(corr4);
      b_wrap = (b_sum >= 34'(gcb_pkg::DEG360)) ? b_sum - 34'(gcb_pkg::DEG360) : b_sum;
      bearing_in = d3_eq_ff ? '0 : 32'(b_wrap);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zs_ff <= zs_in;
         zs_eq_ff <= vf_o.eq;
         d1_n_ff <= 64'(zs_ff) * 64'(gcb_pkg::DEG180) + 64'(gcb_pkg::PI_HALF);
         d1_eq_ff <= zs_eq_ff;
         d2_q_ff <= p2[64:32];
         d2_nl_ff <= d1_n_ff[34:0];
         d2_eq_ff <= d1_eq_ff;
         d3_q_ff <= d2_q_ff;
         d3_rem_ff <= d2_nl_ff - p3[34:0];
         d3_eq_ff <= d2_eq_ff;
         out_bearing_ff <= bearing_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         w_v_ff <= 1'b0;
         sc_v_ff <= '0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         vv_ff <= '0;
         zs_v_ff <= 1'b0;
         d1_v_ff <= 1'b0;
         d2_v_ff <= 1'b0;
         d3_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_ch.valid;
         w_v_ff <= in_v_ff;
         sc_v_ff <= {sc_v_ff[SC_LAT-2:0], w_v_ff};
         m1_v_ff <= sc_v_ff[SC_LAT-1];
         m2_v_ff <= m1_v_ff;
         vv_ff <= {vv_ff[CORDIC_STAGES-1:0], m2_v_ff};
         zs_v_ff <= vv_ff[CORDIC_STAGES];
         d1_v_ff <= zs_v_ff;
         d2_v_ff <= d1_v_ff;
         d3_v_ff <= d2_v_ff;
         out_v_ff <= d3_v_ff;
      end
   end

endmodule
